// ===== hw/rtl/lr_pkg.sv =====
// Package: shared types, widths and codes of the line rasterizer.
`default_nettype none
package lr_pkg;

    localparam int COORD_BITS_DEF = 6;
    localparam int COORD_W        = 6;
    localparam int DIM_BITS       = 7;
    localparam int IDX_BITS       = 12;
    localparam int CHAN_BITS      = 8;
    localparam int CFG_IDX_BITS   = 1;

    localparam logic [DIM_BITS-1:0] FRAME_DIM_RESET = 7'd64;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0]   x_start;
        logic [COORD_W-1:0]   y_start;
        logic [COORD_W-1:0]   x_end;
        logic [COORD_W-1:0]   y_end;
        logic [CHAN_BITS-1:0] red_in;
        logic [CHAN_BITS-1:0] green_in;
        logic [CHAN_BITS-1:0] blue_in;
        logic [CHAN_BITS-1:0] alpha_in;
    } lr_in_t;

    typedef struct packed {
        logic [COORD_W-1:0]   pixel_x;
        logic [COORD_W-1:0]   pixel_y;
        logic [IDX_BITS-1:0]  pixel_index;
        logic                 inside_res;
        logic [CHAN_BITS-1:0] red_out;
        logic [CHAN_BITS-1:0] green_out;
        logic [CHAN_BITS-1:0] blue_out;
        logic [CHAN_BITS-1:0] alpha_out;
        logic                 last;
    } lr_out_t;

    typedef struct packed {
        logic                in_frame;
        logic [IDX_BITS-1:0] index;
    } lr_loc_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP_AXIS,
        ST_SETUP_ORDER,
        ST_WALK
    } lr_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lr_index.sv =====
// Frame clip test and bottom-up flipped buffer index of one pixel.
`default_nettype none
module lr_index
    import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic [COORD_BITS-1:0] px,
    input  wire logic [COORD_BITS-1:0] py,
    input  wire logic [DIM_BITS-1:0]   frame_width,
    input  wire logic [DIM_BITS-1:0]   frame_height,
    output lr_loc_t                    loc
);

    logic [DIM_BITS-1:0]     px_ext;
    logic [DIM_BITS-1:0]     py_ext;
    logic [DIM_BITS-1:0]     row;
    logic [2*DIM_BITS-1:0]   prod;
    logic [2*DIM_BITS:0]     sum;
    logic                    in_frame;

    assign px_ext   = DIM_BITS'(px);
    assign py_ext   = DIM_BITS'(py);
    assign in_frame = (px_ext < frame_width) && (py_ext < frame_height);
    assign row      = frame_height - 7'd1 - py_ext;
    assign prod     = (2*DIM_BITS)'(row) * (2*DIM_BITS)'(frame_width);
    assign sum      = (2*DIM_BITS+1)'(prod) + (2*DIM_BITS+1)'(px_ext);

    always_comb begin
        loc.in_frame = in_frame;
        loc.index    = in_frame ? sum[IDX_BITS-1:0] : '0;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/line_rasterizer_top.sv =====
// Top level: Bresenham line walk with frame clip and buffer index per pixel.
//
//  channel | ports                          | moves
//  --------+--------------------------------+------------------------------
//  s_      | s_valid, s_ready, s_data       | one segment item, lr_in_t
//  m_      | m_valid, m_ready, m_data       | one pixel item, lr_out_t
//  cfg_    | cfg_wr_en, cfg_index, cfg_wdata| frame width / height writes
//
// An item passes the setup states ST_SETUP_AXIS and ST_SETUP_ORDER, then ST_WALK
// emits one pixel per cycle along the major axis while the output does not stall,
// using the single shared error-term adder/compare.
// Output stalls freeze the walk; s_ready is high only while no walk runs.
// The last pixel sits in the output register while the next item enters.
// Reset clears the sequencer, output valid and sets both frame sizes to 64.
`default_nettype none
module line_rasterizer_top
    import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire lr_in_t                  s_data,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output lr_out_t                      m_data,
    input  wire logic                    cfg_wr_en,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [DIM_BITS-1:0]     cfg_wdata
);

    localparam int ERR_BITS = COORD_BITS + 3;

    lr_state_t state_reg, state_next;

    lr_in_t  in_reg, in_next;
    lr_out_t out_reg, out_next;
    logic    out_valid_reg, out_valid_next;

    logic [DIM_BITS-1:0] frame_width_reg, frame_width_next;
    logic [DIM_BITS-1:0] frame_height_reg, frame_height_next;

    logic                       steep_reg, steep_next;
    logic [COORD_BITS-1:0]      major_reg, major_next;
    logic [COORD_BITS-1:0]      minor_reg, minor_next;
    logic [COORD_BITS-1:0]      end_reg, end_next;
    logic [COORD_BITS-1:0]      bend_reg, bend_next;
    logic [COORD_BITS-1:0]      dx_reg, dx_next;
    logic [COORD_BITS:0]        derr2_reg, derr2_next;
    logic signed [ERR_BITS-1:0] err_reg, err_next;
    logic                       step_up_reg, step_up_next;

    logic [COORD_BITS-1:0] x0, y0, x1, y1;
    logic [COORD_BITS-1:0] adx, ady;
    logic                  steep_c;
    logic                  swap_c;
    logic [COORD_BITS-1:0] lo_c, hi_c, mlo_c, mhi_c, mdiff_c;
    logic signed [ERR_BITS-1:0] err_sum;
    logic                  minor_step;
    logic [COORD_BITS-1:0] px, py;
    logic                  load;
    logic                  at_end;
    lr_loc_t               loc;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign x0 = in_reg.x_start[COORD_BITS-1:0];
    assign y0 = in_reg.y_start[COORD_BITS-1:0];
    assign x1 = in_reg.x_end[COORD_BITS-1:0];
    assign y1 = in_reg.y_end[COORD_BITS-1:0];

    assign adx     = (x0 > x1) ? x0 - x1 : x1 - x0;
    assign ady     = (y0 > y1) ? y0 - y1 : y1 - y0;
    assign steep_c = adx < ady;

    assign swap_c  = major_reg > end_reg;
    assign lo_c    = swap_c ? end_reg : major_reg;
    assign hi_c    = swap_c ? major_reg : end_reg;
    assign mlo_c   = swap_c ? bend_reg : minor_reg;
    assign mhi_c   = swap_c ? minor_reg : bend_reg;
    assign mdiff_c = (mhi_c > mlo_c) ? mhi_c - mlo_c : mlo_c - mhi_c;

    assign err_sum    = err_reg + $signed({2'b00, derr2_reg});
    assign minor_step = err_sum > $signed({3'b000, dx_reg});

    assign px     = steep_reg ? minor_reg : major_reg;
    assign py     = steep_reg ? major_reg : minor_reg;
    assign at_end = (major_reg == end_reg);
    assign load   = (state_reg == ST_WALK) && (!out_valid_reg || m_ready);

    lr_index #(
        .COORD_BITS(COORD_BITS)
    ) u_index (
        .px           (px),
        .py           (py),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .loc          (loc)
    );

    always_comb begin
        state_next        = state_reg;
        in_next           = in_reg;
        out_next          = out_reg;
        out_valid_next    = out_valid_reg;
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        steep_next        = steep_reg;
        major_next        = major_reg;
        minor_next        = minor_reg;
        end_next          = end_reg;
        bend_next         = bend_reg;
        dx_next           = dx_reg;
        derr2_next        = derr2_reg;
        err_next          = err_reg;
        step_up_next      = step_up_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_next  = cfg_wdata;
                CFG_FRAME_HEIGHT: frame_height_next = cfg_wdata;
                default: ;
            endcase
        end

        if (m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = ST_SETUP_AXIS;
                end
            end
            ST_SETUP_AXIS: begin
                steep_next = steep_c;
                major_next = steep_c ? y0 : x0;
                minor_next = steep_c ? x0 : y0;
                end_next   = steep_c ? y1 : x1;
                bend_next  = steep_c ? x1 : y1;
                state_next = ST_SETUP_ORDER;
            end
            ST_SETUP_ORDER: begin
                major_next   = lo_c;
                minor_next   = mlo_c;
                end_next     = hi_c;
                dx_next      = hi_c - lo_c;
                derr2_next   = {mdiff_c, 1'b0};
                step_up_next = mhi_c > mlo_c;
                err_next     = '0;
                state_next   = ST_WALK;
            end
            ST_WALK: begin
                if (load) begin
                    out_valid_next       = 1'b1;
                    out_next.pixel_x     = COORD_W'(px);
                    out_next.pixel_y     = COORD_W'(py);
                    out_next.pixel_index = loc.index;
                    out_next.inside_res  = loc.in_frame;
                    out_next.red_out     = in_reg.red_in;
                    out_next.green_out   = in_reg.green_in;
                    out_next.blue_out    = in_reg.blue_in;
                    out_next.alpha_out   = in_reg.alpha_in;
                    out_next.last        = at_end;
                    major_next           = major_reg + 1'b1;
                    if (minor_step) begin
                        minor_next = step_up_reg ? minor_reg + 1'b1 : minor_reg - 1'b1;
                        err_next   = err_sum - $signed({2'b00, dx_reg, 1'b0});
                    end else begin
                        err_next = err_sum;
                    end
                    if (at_end) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            frame_width_reg  <= FRAME_DIM_RESET;
            frame_height_reg <= FRAME_DIM_RESET;
        end else begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg      <= in_next;
        out_reg     <= out_next;
        steep_reg   <= steep_next;
        major_reg   <= major_next;
        minor_reg   <= minor_next;
        end_reg     <= end_next;
        bend_reg    <= bend_next;
        dx_reg      <= dx_next;
        derr2_reg   <= derr2_next;
        err_reg     <= err_next;
        step_up_reg <= step_up_next;
    end

endmodule
`default_nettype wire
